// File: rtl/mcpf_pkg.sv
// shared constants, types and helpers for the multi-channel pipe fifo
`default_nettype none

package mcpf_pkg;

    // table geometry
    localparam int NUM_PIPES   = 8;
    localparam int PIPE_DEPTH  = 1024;
    localparam int ID_BASE     = 4;
    localparam int USER_MAX    = 255;
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int CMD_W    = 3;
    localparam int ID_W     = 4;
    localparam int DATA_W   = 8;
    localparam int STAT_W   = 3;
    localparam int AMOUNT_W = 11;
    localparam int USER_W   = 8;

    // derived widths
    localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
    localparam int ADDR_W = SLOT_W + PTR_W;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EOF   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INFO  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STAT_W-1:0] ST_EOF     = 3'd5;

    // classified command as held in the queue
    typedef struct packed {
        logic              alloc;
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   pipe_id;
        logic              id_ok;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] wdata;
        logic              last;
    } t_cmd_item;

    // queue head presented to the back end
    typedef struct packed {
        logic      valid;
        t_cmd_item item;
    } t_queue_head;

    // circular pointer step with wrap at the buffer depth
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] nxt;
        nxt = {1'b0, p} + (PTR_W+1)'(1);
        return (nxt >= (PTR_W+1)'(PIPE_DEPTH)) ? '0 : nxt[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/multi_channel_pipe_fifo_top.sv
// top level of the multi-channel pipe fifo
//
// channel   direction  handshake          payload
// command   in         i_valid / o_stall  i_cmd, i_pipe_id, i_write_data, i_last_byte
// result    out        o_valid / i_stall  o_status, o_result_id, o_read_data,
//                                         o_stored_amount, o_eof_flag, o_last_out
//
// one command per cycle sustained while i_stall stays low; the single execute stage
// of the back end, with its one byte-store port, sets that figure
// a command transfer writes the queue; the back end then executes it from the queue
// head into the result register
// synchronous reset clears the slot table and both handshakes; the byte store is
// not cleared, only filled bytes are ever read
// o_stall rises when the two-entry command queue is full; a stalled result holds
// in the output register while the queue keeps taking commands until it is full
`default_nettype none

module multi_channel_pipe_fifo_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mcpf_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [mcpf_pkg::ID_W-1:0]     i_pipe_id,
    input  wire logic [mcpf_pkg::DATA_W-1:0]   i_write_data,
    input  wire logic                          i_last_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mcpf_pkg::STAT_W-1:0]        o_status,
    output logic [mcpf_pkg::ID_W-1:0]          o_result_id,
    output logic [mcpf_pkg::DATA_W-1:0]        o_read_data,
    output logic [mcpf_pkg::AMOUNT_W-1:0]      o_stored_amount,
    output logic                               o_eof_flag,
    output logic                               o_last_out
);
    import mcpf_pkg::*;

    t_queue_head q_head;
    logic        q_pop;

    // command classification and queue
    mcpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_pipe_id    (i_pipe_id),
        .i_write_data (i_write_data),
        .i_last_byte  (i_last_byte),
        .o_head       (q_head),
        .i_pop        (q_pop)
    );

    // pipe table execution and result register
    mcpf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_read_data     (o_read_data),
        .o_stored_amount (o_stored_amount),
        .o_eof_flag      (o_eof_flag),
        .o_last_out      (o_last_out)
    );

endmodule

`default_nettype wire

// File: rtl/mcpf_front.sv
// front end: command classification and a short command queue
`default_nettype none

module mcpf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mcpf_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [mcpf_pkg::ID_W-1:0]     i_pipe_id,
    input  wire logic [mcpf_pkg::DATA_W-1:0]   i_write_data,
    input  wire logic                          i_last_byte,
    output mcpf_pkg::t_queue_head              o_head,
    input  wire logic                          i_pop
);
    import mcpf_pkg::*;

    t_cmd_item           cls_item;
    logic [ID_W-1:0]     id_off;
    logic                push;
    t_cmd_item           r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;

    // classify the incoming command: allocation and static id range
    always_comb begin
        id_off           = i_pipe_id - ID_W'(ID_BASE);
        cls_item.alloc   = (i_cmd == CMD_OPEN) && (i_pipe_id == '0);
        cls_item.cmd     = i_cmd;
        cls_item.pipe_id = i_pipe_id;
        cls_item.id_ok   = (i_pipe_id >= ID_W'(ID_BASE)) && (32'(id_off) < 32'(NUM_PIPES));
        cls_item.slot    = SLOT_W'(id_off);
        cls_item.wdata   = i_write_data;
        cls_item.last    = i_last_byte;
    end

    // queue control
    assign o_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_item;
        end
    end

    // head of queue
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/mcpf_back.sv
// back end: pipe table, byte store and result register
`default_nettype none

module mcpf_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mcpf_pkg::t_queue_head         i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mcpf_pkg::STAT_W-1:0]        o_status,
    output logic [mcpf_pkg::ID_W-1:0]          o_result_id,
    output logic [mcpf_pkg::DATA_W-1:0]        o_read_data,
    output logic [mcpf_pkg::AMOUNT_W-1:0]      o_stored_amount,
    output logic                               o_eof_flag,
    output logic                               o_last_out
);
    import mcpf_pkg::*;

    t_cmd_item            it;
    logic                 go;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_slot;
    logic [SLOT_W-1:0]    exec_slot;
    logic                 live;

    // per-slot table
    logic                 r_used  [NUM_PIPES];
    logic [USER_W-1:0]    r_users [NUM_PIPES];
    logic [PTR_W-1:0]     r_head  [NUM_PIPES];
    logic [PTR_W-1:0]     r_tail  [NUM_PIPES];
    logic [FILL_W-1:0]    r_fill  [NUM_PIPES];
    logic                 r_eof   [NUM_PIPES];

    logic                 cur_used;
    logic [USER_W-1:0]    cur_users;
    logic [PTR_W-1:0]     cur_head;
    logic [PTR_W-1:0]     cur_tail;
    logic [FILL_W-1:0]    cur_fill;
    logic                 cur_eof;

    logic                 n_used;
    logic [USER_W-1:0]    n_users;
    logic [PTR_W-1:0]     n_head;
    logic [PTR_W-1:0]     n_tail;
    logic [FILL_W-1:0]    n_fill;
    logic                 n_eof;
    logic [USER_W-1:0]    dec_users;

    logic [STAT_W-1:0]    res_status;
    logic [ID_W-1:0]      res_id;
    logic                 has_slot;
    logic                 rd_ok;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_addr;

    // byte store
    logic [DATA_W-1:0]    mem [2**ADDR_W];
    logic [DATA_W-1:0]    r_ram_q;

    // result register
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [ID_W-1:0]      r_rid;
    logic [AMOUNT_W-1:0]  r_amount;
    logic                 r_eof_out;
    logic                 r_last;
    logic                 r_is_rd;

    assign it    = i_head.item;
    assign go    = i_head.valid && (!r_out_valid || !i_stall);
    assign o_pop = go;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // slot under work and its current entry
    assign exec_slot = it.alloc ? free_slot : it.slot;
    assign cur_used  = r_used[exec_slot];
    assign cur_users = r_users[exec_slot];
    assign cur_head  = r_head[exec_slot];
    assign cur_tail  = r_tail[exec_slot];
    assign cur_fill  = r_fill[exec_slot];
    assign cur_eof   = r_eof[exec_slot];
    assign live      = it.id_ok && cur_used;
    assign dec_users = (cur_users != '0) ? cur_users - USER_W'(1) : '0;

    // command execution
    always_comb begin
        n_used     = cur_used;
        n_users    = cur_users;
        n_head     = cur_head;
        n_tail     = cur_tail;
        n_fill     = cur_fill;
        n_eof      = cur_eof;
        res_status = ST_INVALID;
        res_id     = it.pipe_id;
        has_slot   = 1'b0;
        rd_ok      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = {exec_slot, cur_tail};
        if (it.alloc) begin
            res_id     = '0;
            res_status = ST_NOSPACE;
            if (free_found) begin
                n_used     = 1'b1;
                n_users    = USER_W'(1);
                n_head     = '0;
                n_tail     = '0;
                n_fill     = '0;
                n_eof      = 1'b0;
                res_id     = ID_W'(32'(free_slot) + ID_BASE);
                res_status = ST_OK;
                has_slot   = 1'b1;
            end
        end else if (live) begin
            res_status = ST_OK;
            has_slot   = 1'b1;
            unique case (it.cmd)
                CMD_OPEN: begin
                    if (cur_users < USER_W'(USER_MAX)) begin
                        n_users = cur_users + USER_W'(1);
                    end
                end
                CMD_CLOSE: begin
                    n_users = dec_users;
                    if (dec_users == '0) begin
                        n_used = 1'b0;
                        n_head = '0;
                        n_tail = '0;
                        n_fill = '0;
                        n_eof  = 1'b0;
                    end
                end
                CMD_WRITE: begin
                    if (cur_fill >= FILL_W'(PIPE_DEPTH)) begin
                        res_status = ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        ram_addr = {exec_slot, cur_tail};
                        n_tail   = ptr_advance(cur_tail);
                        n_fill   = cur_fill + FILL_W'(1);
                    end
                end
                CMD_READ: begin
                    if (cur_fill == '0) begin
                        res_status = cur_eof ? ST_EOF : ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        rd_ok    = 1'b1;
                        ram_addr = {exec_slot, cur_head};
                        n_head   = ptr_advance(cur_head);
                        n_fill   = cur_fill - FILL_W'(1);
                    end
                end
                CMD_EOF: begin
                    n_eof = 1'b1;
                end
                CMD_INFO: begin
                    n_eof = cur_eof;
                end
                default: begin
                    // undefined command codes change nothing
                    res_status = ST_INVALID;
                    has_slot   = 1'b0;
                end
            endcase
        end
    end

    // slot table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_used[i]  <= 1'b0;
                r_users[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_fill[i]  <= '0;
                r_eof[i]   <= 1'b0;
            end
        end else if (go) begin
            r_used[exec_slot]  <= n_used;
            r_users[exec_slot] <= n_users;
            r_head[exec_slot]  <= n_head;
            r_tail[exec_slot]  <= n_tail;
            r_fill[exec_slot]  <= n_fill;
            r_eof[exec_slot]   <= n_eof;
        end
    end

    // byte store with registered read
    always_ff @(posedge i_clk) begin
        if (go && ram_we) begin
            mem[ram_addr] <= it.wdata;
        end
        if (go && ram_re) begin
            r_ram_q <= mem[ram_addr];
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status  <= res_status;
            r_rid     <= res_id;
            r_amount  <= has_slot ? AMOUNT_W'(n_fill) : '0;
            r_eof_out <= has_slot && n_eof;
            r_last    <= it.last;
            r_is_rd   <= rd_ok;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_result_id     = r_rid;
    assign o_read_data     = r_is_rd ? r_ram_q : '0;
    assign o_stored_amount = r_amount;
    assign o_eof_flag      = r_eof_out;
    assign o_last_out      = r_last;

`ifndef SYNTHESIS
    // fill count of the slot at work never exceeds the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> (32'(cur_fill) <= 32'(PIPE_DEPTH)))
        else $error("fill count above pipe depth");

    // an open pipe always has at least one user
    a_users_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && cur_used) |-> (cur_users != '0))
        else $error("open pipe with no users");

    // allocation only picks a free slot
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && it.alloc && free_found) |-> !r_used[free_slot])
        else $error("allocation of a used slot");

    // a returned byte always carries an ok status
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_rd) |-> (r_status == ST_OK))
        else $error("read data with failing status");

    // every executed command yields a pending result
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> r_out_valid)
        else $error("executed command without result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/multi_channel_pipe_fifo_top_tb.sv
// self-checking testbench for the multi-channel pipe fifo: driver, monitor, table predictor
`timescale 1ns / 100ps

module multi_channel_pipe_fifo_top_tb;
    import mcpf_pkg::*;

    // command codes outside the defined set, and the allocating id
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam logic [ID_W-1:0]  ID_ALLOC    = '0;

    localparam int STUCK_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 415;
    localparam int BACKLOG_DEPTH = 4;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_pipe_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [ID_W-1:0]     rid;
        logic [DATA_W-1:0]   rdata;
        logic [AMOUNT_W-1:0] amount;
        logic                eof;
        logic                last;
    } t_pipe_reply;

    typedef struct {
        t_pipe_cmd item;
        bit        settle;
    } t_pending_cmd;

    // dut connections
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [ID_W-1:0]     i_pipe_id = '0;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic                i_last_byte = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [ID_W-1:0]     o_result_id;
    logic [DATA_W-1:0]   o_read_data;
    logic [AMOUNT_W-1:0] o_stored_amount;
    logic                o_eof_flag;
    logic                o_last_out;

    // predicted pipe table
    bit                  slot_live  [NUM_PIPES];
    bit [USER_W-1:0]     users      [NUM_PIPES];
    bit [PTR_W-1:0]      rd_pos     [NUM_PIPES];
    bit [PTR_W-1:0]      wr_pos     [NUM_PIPES];
    bit [FILL_W-1:0]     fill_level [NUM_PIPES];
    bit                  eof_set    [NUM_PIPES];
    bit [DATA_W-1:0]     pipe_bytes [NUM_PIPES*PIPE_DEPTH];
    int                  live_pipes = 0;

    // traffic bookkeeping
    t_pending_cmd backlog[$];
    t_pipe_reply  awaited[$];
    int  pushed_cmds   = 0;
    int  accepted_cmds = 0;
    int  offered_cmds  = 0;
    int  replies_seen  = 0;
    int  stuck_cycles  = 0;
    int  fault_count   = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    bit  cmd_xfer      = 1'b0;
    bit  reply_xfer    = 1'b0;
    bit  snd_quiet     = 1'b0;
    bit  rcv_quiet     = 1'b0;

    multi_channel_pipe_fifo_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_pipe_id       (i_pipe_id),
        .i_write_data    (i_write_data),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_read_data     (o_read_data),
        .o_stored_amount (o_stored_amount),
        .o_eof_flag      (o_eof_flag),
        .o_last_out      (o_last_out)
    );

    // clock and reset
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // circular position step, wrapping at the buffer depth
    function automatic bit [PTR_W-1:0] next_pos(input bit [PTR_W-1:0] p);
        return (int'(p) == PIPE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // applies one command to the predicted table and returns its reply
    function automatic t_pipe_reply run_pipe_command(input t_pipe_cmd c);
        t_pipe_reply r;
        int          slot;
        int          idn;
        int          i;
        r.status = ST_INVALID;
        r.rid    = c.id;
        r.rdata  = '0;
        r.amount = '0;
        r.eof    = 1'b0;
        r.last   = c.last;
        slot     = -1;
        idn      = int'(c.id);
        if (c.op == CMD_OPEN && c.id == ID_ALLOC) begin
            // allocate the lowest free slot
            r.rid    = '0;
            r.status = ST_NOSPACE;
            if (live_pipes < NUM_PIPES) begin
                for (i = 0; i < NUM_PIPES; i++) begin
                    if (slot < 0 && !slot_live[i]) begin
                        slot          = i;
                        slot_live[i]  = 1'b1;
                        users[i]      = USER_W'(1);
                        rd_pos[i]     = '0;
                        wr_pos[i]     = '0;
                        fill_level[i] = '0;
                        eof_set[i]    = 1'b0;
                        live_pipes++;
                        r.rid    = ID_W'(i + ID_BASE);
                        r.status = ST_OK;
                    end
                end
            end
        end else if (c.op <= CMD_INFO && idn >= ID_BASE && idn - ID_BASE < NUM_PIPES
                     && slot_live[idn - ID_BASE]) begin
            slot     = idn - ID_BASE;
            r.status = ST_OK;
            case (c.op)
                CMD_OPEN: begin
                    if (users[slot] != USER_MAX) users[slot]++;
                end
                CMD_CLOSE: begin
                    if (users[slot] != 0) users[slot]--;
                    if (users[slot] == 0) begin
                        slot_live[slot]  = 1'b0;
                        rd_pos[slot]     = '0;
                        wr_pos[slot]     = '0;
                        fill_level[slot] = '0;
                        eof_set[slot]    = 1'b0;
                        if (live_pipes > 0) live_pipes--;
                    end
                end
                CMD_WRITE: begin
                    if (fill_level[slot] >= PIPE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pipe_bytes[slot*PIPE_DEPTH + wr_pos[slot]] = c.data;
                        wr_pos[slot] = next_pos(wr_pos[slot]);
                        fill_level[slot]++;
                    end
                end
                CMD_READ: begin
                    if (fill_level[slot] == 0) begin
                        r.status = eof_set[slot] ? ST_EOF : ST_EMPTY;
                    end else begin
                        r.rdata = pipe_bytes[slot*PIPE_DEPTH + rd_pos[slot]];
                        rd_pos[slot] = next_pos(rd_pos[slot]);
                        fill_level[slot]--;
                    end
                end
                CMD_EOF: begin
                    eof_set[slot] = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (slot >= 0) begin
            r.amount = AMOUNT_W'(fill_level[slot]);
            r.eof    = eof_set[slot];
        end
        return r;
    endfunction

    // monitor: command and reply transfers, reply checks, watchdog
    always @(posedge i_clk) begin
        t_pipe_reply want;
        cmd_xfer   = 1'b0;
        reply_xfer = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                reply_xfer = 1'b1;
                replies_seen++;
                if (awaited.size() == 0) begin
                    $error("reply with no command outstanding");
                    fault_count++;
                end else begin
                    want = awaited.pop_front();
                    if (o_status !== want.status) begin
                        $error("o_status: expected %0d, actual %0d", want.status, o_status);
                        fault_count++;
                    end
                    if (o_result_id !== want.rid) begin
                        $error("o_result_id: expected %0d, actual %0d", want.rid, o_result_id);
                        fault_count++;
                    end
                    if (o_read_data !== want.rdata) begin
                        $error("o_read_data: expected %0d, actual %0d", want.rdata, o_read_data);
                        fault_count++;
                    end
                    if (o_stored_amount !== want.amount) begin
                        $error("o_stored_amount: expected %0d, actual %0d",
                               want.amount, o_stored_amount);
                        fault_count++;
                    end
                    if (o_eof_flag !== want.eof) begin
                        $error("o_eof_flag: expected %0d, actual %0d", want.eof, o_eof_flag);
                        fault_count++;
                    end
                    if (o_last_out !== want.last) begin
                        $error("o_last_out: expected %0d, actual %0d", want.last, o_last_out);
                        fault_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                cmd_xfer = 1'b1;
                accepted_cmds++;
                awaited.push_back(run_pipe_command({i_cmd, i_pipe_id, i_write_data,
                                                    i_last_byte}));
            end
            if (cmd_xfer || reply_xfer) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // command driver, fed from the backlog
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !cmd_xfer) begin
            // offered command not taken yet, hold it
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left--;
        end else if (backlog.size() == 0 || (backlog[0].settle && awaited.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            i_valid      <= 1'b1;
            i_cmd        <= backlog[0].item.op;
            i_pipe_id    <= backlog[0].item.id;
            i_write_data <= backlog[0].item.data;
            i_last_byte  <= backlog[0].item.last;
            backlog.pop_front();
            if (offered_cmds % 50 == 0) snd_quiet = ($urandom_range(0, 2) == 0);
            offered_cmds++;
            gap_left = snd_quiet ? 0 : $urandom_range(0, 8);
        end
    end

    // reply receiver: random stalls, now and then one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (reply_xfer) begin
                if (replies_seen % 64 == 0) rcv_quiet = ($urandom_range(0, 2) == 0);
                if (replies_seen % 1500 == 40) hold_left = 80;
                else hold_left = rcv_quiet ? 0 : $urandom_range(0, 8);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // adds one command to the backlog, keeping it short
    task automatic queue_command(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [DATA_W-1:0] data, input logic last,
                                 input bit settle);
        t_pending_cmd p;
        while (backlog.size() >= BACKLOG_DEPTH) @(posedge i_clk);
        p.item   = {op, id, data, last};
        p.settle = settle;
        backlog.push_back(p);
        pushed_cmds++;
    endtask

    // mostly well-formed traffic on live pipes, some noise
    task automatic queue_random_command(input bit settle);
        logic [CMD_W-1:0] op;
        logic [ID_W-1:0]  id;
        int               roll;
        int               i;
        int               live_ids[$];
        for (i = 0; i < NUM_PIPES; i++) begin
            if (slot_live[i]) live_ids.push_back(i + ID_BASE);
        end
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            op = CMD_W'($urandom_range(0, 7));
            id = ID_W'($urandom_range(0, 15));
        end else if (live_ids.size() == 0 || roll < 17) begin
            op = CMD_OPEN;
            id = ID_ALLOC;
        end else begin
            id = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
            if (roll < 52)      op = CMD_WRITE;
            else if (roll < 82) op = CMD_READ;
            else if (roll < 86) op = CMD_OPEN;
            else if (roll < 91) op = CMD_CLOSE;
            else if (roll < 95) op = CMD_EOF;
            else                op = CMD_INFO;
        end
        queue_command(op, id, DATA_W'($urandom), 1'($urandom_range(0, 1)), settle);
    endtask

    // stimulus and end of run
    initial begin
        int k;

        // directed: one pipe through its life, bad ids, spare codes
        queue_command(CMD_OPEN,    ID_ALLOC, 8'h00, 1'b1, 1'b0);
        queue_command(CMD_INFO,    4'd4,  8'h00, 1'b0, 1'b0);
        queue_command(CMD_WRITE,   4'd4,  8'hFF, 1'b0, 1'b0);
        queue_command(CMD_WRITE,   4'd4,  8'h00, 1'b1, 1'b0);
        queue_command(CMD_WRITE,   4'd4,  8'hA5, 1'b0, 1'b0);
        for (k = 0; k < 4; k++) queue_command(CMD_READ, 4'd4, 8'hFF, k[0], 1'b0);
        queue_command(CMD_EOF,     4'd4,  8'h00, 1'b0, 1'b0);
        queue_command(CMD_READ,    4'd4,  8'h00, 1'b1, 1'b0);
        queue_command(CMD_WRITE,   4'd4,  8'h5A, 1'b0, 1'b0);
        queue_command(CMD_READ,    4'd4,  8'h00, 1'b0, 1'b0);
        queue_command(CMD_INFO,    4'd0,  8'h00, 1'b0, 1'b0);
        queue_command(CMD_INFO,    4'd3,  8'h00, 1'b1, 1'b0);
        queue_command(CMD_INFO,    4'd12, 8'h00, 1'b0, 1'b0);
        queue_command(CMD_INFO,    4'd15, 8'hFF, 1'b1, 1'b0);
        queue_command(CMD_WRITE,   4'd9,  8'h33, 1'b0, 1'b0);
        queue_command(CMD_SPARE_6, 4'd4,  8'h00, 1'b0, 1'b0);
        queue_command(CMD_SPARE_7, 4'd15, 8'hFF, 1'b1, 1'b0);
        queue_command(CMD_OPEN,    4'd4,  8'h00, 1'b0, 1'b0);
        for (k = 0; k < 3; k++) queue_command(CMD_CLOSE, 4'd4, 8'h00, 1'b0, 1'b0);
        queue_command(CMD_CLOSE,   4'd0,  8'h00, 1'b0, 1'b0);

        // fill the whole table, then one open too many
        for (k = 0; k <= NUM_PIPES; k++) queue_command(CMD_OPEN, ID_ALLOC, 8'h00, 1'b0, 1'b0);
        queue_command(CMD_INFO, 4'd11, 8'h00, 1'b0, 1'b0);

        // random traffic, pausing for a full drain every hundred commands
        for (k = 0; k < RANDOM_ITEMS; k++) queue_random_command(k % 100 == 0);

        while (accepted_cmds != pushed_cmds || awaited.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
